/* sv/mqf_pkg.sv */
`default_nettype none
package mqf_pkg;

    // Field widths of the ports.
    localparam int OPC_W   = 2;
    localparam int IDX_W   = 9;
    localparam int ENTRY_W = 40;
    localparam int MAG_W   = 32;
    localparam int CFG_W   = 10;
    localparam int CHI_W   = 64;

    // Internal fixed-point widths.
    localparam int RESID_W = MAG_W + 1;
    localparam int PROD_W  = ENTRY_W + RESID_W;
    localparam int TOTAL_W = 64;
    localparam int FRAC_W  = 24;

    // Defaults.
    localparam int MAX_POINTS_DEF = 512;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(307);

    // Operation codes of an input transaction.
    typedef enum logic [OPC_W-1:0] {
        OP_MATRIX  = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } mqf_op_t;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WALK  = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_PMUL  = 7'b0001000,
        ST_SQ    = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } mqf_state_t;

endpackage
`default_nettype wire

/* sv/marginalized_quadratic_form.sv */
`default_nettype none
// Marginalized chi-square quadratic form. Opcode 0 writes one inverse covariance entry
// and opcode 1 one sample (its residual is stored); the block takes one such transaction
// per clock while idle. Opcode 2 walks the first n rows and columns of the matrix store,
// n = active_points capped at MAX_POINTS, one entry per cycle through its single read
// port. At the end of each row it drains the read pipeline and then runs a serial multiply
// of the row product by the residual. After the last row come a serial square of the
// S_W-bit sum of row products (S_W is 70 at 512 points) and a bit-serial divide, both
// skipped when the total of the matrix entries is zero, and then the final step. The
// block takes no item during a compute; configuration writes are always taken. The result
// waits in an output register, so loads can go on while it is not yet taken.
module marginalized_quadratic_form
    #(
    parameter int MAX_POINTS = mqf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [mqf_pkg::OPC_W-1:0]    opcode,
    input  wire logic        [mqf_pkg::IDX_W-1:0]    row,
    input  wire logic        [mqf_pkg::IDX_W-1:0]    col,
    input  wire logic signed [mqf_pkg::ENTRY_W-1:0]  matrix_entry,
    input  wire logic        [mqf_pkg::MAG_W-1:0]    model_modulus,
    input  wire logic        [mqf_pkg::MAG_W-1:0]    observed_mag,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [mqf_pkg::CHI_W-1:0]    chi_square,
    output logic                                     zero_total,
    output logic                                     saturated,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [mqf_pkg::CFG_W-1:0]    active_points
);

    import mqf_pkg::*;

    localparam int LW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int IA_W   = $clog2(MAX_POINTS * MAX_POINTS);
    localparam int ACC_W  = PROD_W + LW + 1;
    localparam int P_W    = ACC_W + 1 - FRAC_W;
    localparam int PD_W   = P_W + RESID_W;
    localparam int DOT_W  = PD_W + LW + 2;
    localparam int DOTR_W = DOT_W + 1 - FRAC_W;
    localparam int S_W    = P_W + LW + 1;
    localparam int SQ_W   = 2 * S_W;
    localparam int RES_W  = ((DOTR_W > SQ_W + 1) ? DOTR_W : SQ_W + 1) + 1;
    localparam int LO_W   = ENTRY_W / 2;
    localparam int PLO_W  = LO_W + 1 + RESID_W;
    localparam int PHI_W  = ENTRY_W - LO_W + RESID_W;

    mqf_state_t state_reg;

    logic [CFG_W-1:0] active_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    i_reg;
    logic [NW-1:0]    j_reg;
    logic [IA_W-1:0]  base_reg;

    // Walk pipeline.
    logic                       rd_v_reg;
    logic                       rd_diag_reg;
    logic                       p_v_reg;
    logic signed [PLO_W-1:0]    plo_reg;
    logic signed [PHI_W-1:0]    phi_reg;
    logic signed [ENTRY_W-1:0]  m_reg;
    logic signed [RESID_W-1:0]  di_reg;

    // Accumulators.
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [TOTAL_W-1:0]  total_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic signed [S_W-1:0]      s_reg;
    logic signed [P_W-1:0]      p_reg;
    logic [SQ_W-1:0]            q_reg;

    logic pd_go_reg;
    logic ss_go_reg;
    logic div_go_reg;

    logic out_valid_reg;
    logic signed [CHI_W-1:0] chi_reg;
    logic zero_reg;
    logic sat_reg;

    logic in_fire;
    logic inv_we;
    logic res_we;
    logic [IA_W-1:0] inv_waddr;
    logic [IA_W-1:0] inv_raddr;
    logic [ENTRY_W-1:0] inv_rdata;
    logic [RESID_W-1:0] res_wdata;
    logic [RESID_W-1:0] res_rdata;
    logic [NW-1:0] n_new;

    logic [ACC_W:0] acc_rnd;
    logic signed [P_W-1:0] p_new;
    logic [P_W-1:0] abs_p;
    logic [RESID_W-1:0] abs_d;
    logic [PD_W-1:0] pd_prod;
    logic pd_done;
    logic signed [DOT_W-1:0] term;
    logic [S_W-1:0] abs_s;
    logic [SQ_W-1:0] ss_prod;
    logic ss_done;
    logic [TOTAL_W-1:0] tmag;
    logic [SQ_W-1:0] div_q;
    logic div_done;
    logic [DOT_W:0] dot_rnd;
    logic signed [RES_W-1:0] q_signed;
    logic signed [RES_W-1:0] res_full;
    logic res_fits;
    logic out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Store writes from load transactions.
    assign inv_we = in_fire && (opcode == OP_MATRIX)
                    && (32'(row) < MAX_POINTS) && (32'(col) < MAX_POINTS);
    assign res_we = in_fire && (opcode == OP_SAMPLE) && (32'(row) < MAX_POINTS);
    assign inv_waddr = IA_W'(IA_W'(row) * IA_W'(MAX_POINTS) + IA_W'(col));
    assign res_wdata = {1'b0, model_modulus} - {1'b0, observed_mag};
    assign inv_raddr = base_reg + IA_W'(j_reg);

    mqf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS * MAX_POINTS)) u_inv_ram (
        .clk   (clk),
        .we    (inv_we),
        .waddr (inv_waddr),
        .wdata (matrix_entry),
        .raddr (inv_raddr),
        .rdata (inv_rdata)
    );

    mqf_ram #(.WIDTH(RESID_W), .DEPTH(MAX_POINTS)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (LW'(row)),
        .wdata (res_wdata),
        .raddr (j_reg[LW-1:0]),
        .rdata (res_rdata)
    );

    // Active count limited to the store size.
    assign n_new = (32'(active_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(active_reg);

    // Row product rounded to Q.24.
    assign acc_rnd = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(1 << (FRAC_W - 1));
    assign p_new   = acc_rnd[ACC_W:FRAC_W];
    assign abs_p   = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
    assign abs_d   = di_reg[RESID_W-1] ? RESID_W'(-di_reg) : RESID_W'(di_reg);
    assign term    = (p_reg[P_W-1] ^ di_reg[RESID_W-1]) ? -DOT_W'(pd_prod) : DOT_W'(pd_prod);
    assign abs_s   = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);
    assign tmag    = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);

    mqf_mul #(.AW(P_W), .BW(RESID_W)) u_pd_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pd_go_reg),
        .a     (abs_p),
        .b     (abs_d),
        .prod  (pd_prod),
        .done  (pd_done)
    );

    mqf_mul #(.AW(S_W), .BW(S_W)) u_ss_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ss_go_reg),
        .a     (abs_s),
        .b     (abs_s),
        .prod  (ss_prod),
        .done  (ss_done)
    );

    mqf_div #(.NW(SQ_W), .DW(TOTAL_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (ss_prod),
        .divisor  (tmag),
        .quotient (div_q),
        .done     (div_done)
    );

    // Final difference and clamp.
    assign dot_rnd  = {dot_reg[DOT_W-1], dot_reg} + (DOT_W+1)'(1 << (FRAC_W - 1));
    assign q_signed = total_reg[TOTAL_W-1] ? -RES_W'(q_reg) : RES_W'(q_reg);
    assign res_full = RES_W'($signed(dot_rnd[DOT_W:FRAC_W])) - q_signed;
    assign res_fits = (&res_full[RES_W-1:CHI_W-1]) || !(|res_full[RES_W-1:CHI_W-1]);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= active_points;
        end
    end

    // Sequencer and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_v_reg      <= 1'b0;
            p_v_reg       <= 1'b0;
            pd_go_reg     <= 1'b0;
            ss_go_reg     <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pd_go_reg  <= 1'b0;
            ss_go_reg  <= 1'b0;
            div_go_reg <= 1'b0;
            rd_v_reg   <= (state_reg == ST_WALK);
            p_v_reg    <= rd_v_reg;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (opcode == OP_COMPUTE))
                    begin
                        state_reg <= (n_new == '0) ? ST_FIN : ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (j_reg == n_reg - NW'(1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_v_reg && !p_v_reg)
                    begin
                        pd_go_reg <= 1'b1;
                        state_reg <= ST_PMUL;
                    end
                end
                ST_PMUL:
                begin
                    if (pd_done)
                    begin
                        if (i_reg != n_reg - NW'(1))
                        begin
                            state_reg <= ST_WALK;
                        end
                        else if (total_reg == '0)
                        begin
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            ss_go_reg <= 1'b1;
                            state_reg <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (ss_done)
                    begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Read data to two partial products, partial products to accumulators.
        rd_diag_reg <= (j_reg == i_reg);
        plo_reg     <= $signed({1'b0, inv_rdata[LO_W-1:0]}) * $signed(res_rdata);
        phi_reg     <= $signed(inv_rdata[ENTRY_W-1:LO_W]) * $signed(res_rdata);
        m_reg       <= $signed(inv_rdata);
        if (rd_v_reg && rd_diag_reg)
        begin
            di_reg <= $signed(res_rdata);
        end
        if (p_v_reg)
        begin
            acc_reg   <= acc_reg + (ACC_W'(phi_reg) <<< LO_W) + ACC_W'(plo_reg);
            total_reg <= total_reg + TOTAL_W'(m_reg);
        end
        case (state_reg)
            ST_IDLE:
            begin
                n_reg     <= n_new;
                i_reg     <= '0;
                j_reg     <= '0;
                base_reg  <= '0;
                acc_reg   <= '0;
                total_reg <= '0;
                dot_reg   <= '0;
                s_reg     <= '0;
            end
            ST_WALK:
            begin
                j_reg <= (j_reg == n_reg - NW'(1)) ? '0 : j_reg + NW'(1);
            end
            ST_DRAIN:
            begin
                p_reg <= p_new;
            end
            ST_PMUL:
            begin
                if (pd_done)
                begin
                    dot_reg  <= dot_reg + term;
                    s_reg    <= s_reg + S_W'(p_reg);
                    acc_reg  <= '0;
                    i_reg    <= i_reg + NW'(1);
                    base_reg <= base_reg + IA_W'(MAX_POINTS);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    q_reg <= div_q;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (total_reg == '0)
                    begin
                        chi_reg  <= '0;
                        zero_reg <= 1'b1;
                        sat_reg  <= 1'b0;
                    end
                    else
                    begin
                        zero_reg <= 1'b0;
                        sat_reg  <= !res_fits;
                        if (res_fits)
                        begin
                            chi_reg <= CHI_W'(res_full);
                        end
                        else
                        begin
                            chi_reg <= res_full[RES_W-1] ? {1'b1, {(CHI_W-1){1'b0}}}
                                                         : {1'b0, {(CHI_W-1){1'b1}}};
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign chi_square = chi_reg;
    assign zero_total = zero_reg;
    assign saturated  = sat_reg;

`ifndef SYNTHESIS
    // The walk pipeline is empty whenever a new transaction can be taken.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_v_reg && !p_v_reg))
        else $error("walk pipeline busy while idle");

    // A new result appears only out of the final state.
    a_rose_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside final state");

    // A zero total forces a clean zero result.
    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_total) |-> (!saturated && chi_square == '0))
        else $error("zero total with nonzero result");

    // The row multiply is started only once the row has drained.
    a_pd_start: assert property (@(posedge clk) disable iff (!rst_n)
        pd_go_reg |-> (state_reg == ST_PMUL && !p_v_reg))
        else $error("row multiply started early");
`endif

endmodule
`default_nettype wire

/* sv/mqf_ram.sv */
`default_nettype none
module mqf_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* sv/mqf_mul.sv */
`default_nettype none
module mqf_mul #(
    parameter int AW = 60,
    parameter int BW = 33
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic      [AW+BW-1:0] prod,
    output logic                  done
);

    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] a_reg;
    logic [BW-1:0]    b_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Unsigned shift-add multiplier, one multiplier bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= (AW+BW)'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

/* sv/mqf_div.sv */
`default_nettype none
module mqf_div #(
    parameter int NW = 140,
    parameter int DW = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [NW-1:0] quotient,
    output logic               done
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, dsr_reg}) : DW'(trial);
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire
